/* src/ahfp_pkg.sv */
// package: types, constants and character helpers for the ascii hex frame parser
`timescale 1ns / 1ps

package ahfp_pkg;

  // framing
  localparam logic [7:0] START_BYTE = 8'h02;
  localparam logic [7:0] MIN_LENGTH = 8'd2;

  // character codes
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_F = 8'h46;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] HEX_TEN      = 8'd10;

  // byte positions inside a frame
  localparam logic [7:0] POS_AWAIT_START = 8'd0;
  localparam logic [7:0] POS_LENGTH      = 8'd1;
  localparam logic [7:0] POS_PAYLOAD     = 8'd2;
  localparam logic [7:0] POS_GROUP_HI    = 8'd2;
  localparam logic [7:0] POS_GROUP_LO    = 8'd3;
  localparam logic [7:0] POS_INDEX_HI    = 8'd4;
  localparam logic [7:0] POS_INDEX_LO    = 8'd5;
  localparam logic [7:0] POS_BATT_FIRST  = 8'd7;
  localparam logic [7:0] POS_BATT_LAST   = 8'd8;
  localparam logic [7:0] POS_TMO_FIRST   = 8'd9;
  localparam logic [7:0] POS_TMO_LAST    = 8'd12;
  localparam logic [7:0] POS_ENTRY_0     = 8'd14;
  localparam logic [7:0] POS_ENTRY_1     = 8'd15;
  localparam logic [7:0] POS_ENTRY_2     = 8'd16;
  localparam logic [7:0] POS_ENTRY_3     = 8'd17;

  typedef enum logic [1:0] {
    STATUS_GOOD    = 2'd0,
    STATUS_BAD_SUM = 2'd1,
    STATUS_DROPPED = 2'd2
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  group_number;
    logic [7:0]  device_index;
    logic [6:0]  battery_level;
    logic [13:0] timeout_value;
    logic [31:0] entry_chars;
    logic [7:0]  frame_length;
  } record_t;

  // lowercase and anything else fall through to c - 'a' + 10, wrapping
  function automatic logic [7:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      v = c - CHAR_ZERO;
    end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
      v = c - CHAR_UPPER_A + HEX_TEN;
    end else begin
      v = c - CHAR_LOWER_A + HEX_TEN;
    end
    return v;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

endpackage

/* src/ahfp_in_stage.sv */
// input register: holds one received byte until the parser takes it
`timescale 1ns / 1ps

module ahfp_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       take,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  logic accept;

  assign in_stall = held_valid && !take;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_byte <= rx_byte;
    end
  end

endmodule

/* src/ahfp_core.sv */
// parser state and per-byte update, builds the record a byte produces
`timescale 1ns / 1ps

module ahfp_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  logic [7:0]       c,
  output logic             emits,
  output ahfp_pkg::record_t rec
);

  logic [7:0]  byte_position, byte_position_next;
  logic [7:0]  length_seen, length_seen_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [3:0]  checksum_high_nibble, checksum_high_nibble_next;
  logic [7:0]  group_accum, group_accum_next;
  logic [7:0]  index_accum, index_accum_next;
  logic [6:0]  battery_accum, battery_accum_next;
  logic [13:0] timeout_accum, timeout_accum_next;
  logic [31:0] entry_accum, entry_accum_next;
  logic [1:0]  decimal_stopped, decimal_stopped_next;

  logic [7:0] hex;
  logic [3:0] digit;
  logic       dig_ok;
  logic       in_frame;
  logic       full;
  logic [7:0] got_sum;

  assign hex      = ahfp_pkg::hex_value(c);
  assign dig_ok   = ahfp_pkg::is_digit(c);
  assign digit    = 4'(c - ahfp_pkg::CHAR_ZERO);
  assign in_frame = (length_seen != '0);
  assign full     = in_frame && (byte_position == ahfp_pkg::POS_AWAIT_START);
  assign got_sum  = {checksum_high_nibble, 4'b0000} + hex;

  // a byte produces a record on a bad start, a bad length or the last checksum char
  always_comb begin
    if (!in_frame) begin
      if (byte_position == ahfp_pkg::POS_AWAIT_START) begin
        emits = (c != ahfp_pkg::START_BYTE);
      end else begin
        emits = (c < ahfp_pkg::MIN_LENGTH);
      end
    end else begin
      emits = full;
    end
  end

  always_comb begin
    rec.status        = ahfp_pkg::STATUS_DROPPED;
    rec.group_number  = '0;
    rec.device_index  = '0;
    rec.battery_level = '0;
    rec.timeout_value = '0;
    rec.entry_chars   = '0;
    rec.frame_length  = '0;
    if (full) begin
      rec.status        = (got_sum == running_sum) ? ahfp_pkg::STATUS_GOOD
                                                   : ahfp_pkg::STATUS_BAD_SUM;
      rec.group_number  = group_accum;
      rec.device_index  = index_accum;
      rec.battery_level = battery_accum;
      rec.timeout_value = timeout_accum;
      rec.entry_chars   = entry_accum;
      rec.frame_length  = length_seen;
    end else if (!in_frame && byte_position != ahfp_pkg::POS_AWAIT_START) begin
      rec.frame_length = c;
    end
  end

  always_comb begin
    byte_position_next        = byte_position;
    length_seen_next          = length_seen;
    running_sum_next          = running_sum;
    checksum_high_nibble_next = checksum_high_nibble;
    group_accum_next          = group_accum;
    index_accum_next          = index_accum;
    battery_accum_next        = battery_accum;
    timeout_accum_next        = timeout_accum;
    entry_accum_next          = entry_accum;
    decimal_stopped_next      = decimal_stopped;

    if (!in_frame) begin
      if (byte_position == ahfp_pkg::POS_AWAIT_START) begin
        if (c == ahfp_pkg::START_BYTE) begin
          byte_position_next        = ahfp_pkg::POS_LENGTH;
          running_sum_next          = '0;
          checksum_high_nibble_next = '0;
          group_accum_next          = '0;
          index_accum_next          = '0;
          battery_accum_next        = '0;
          timeout_accum_next        = '0;
          entry_accum_next          = '0;
          decimal_stopped_next      = '0;
        end
      end else if (c < ahfp_pkg::MIN_LENGTH) begin
        byte_position_next        = ahfp_pkg::POS_AWAIT_START;
        running_sum_next          = '0;
        checksum_high_nibble_next = '0;
        group_accum_next          = '0;
        index_accum_next          = '0;
        battery_accum_next        = '0;
        timeout_accum_next        = '0;
        entry_accum_next          = '0;
        decimal_stopped_next      = '0;
      end else begin
        length_seen_next   = c;
        running_sum_next   = c;
        byte_position_next = ahfp_pkg::POS_PAYLOAD;
      end
    end else if (byte_position == ahfp_pkg::POS_AWAIT_START) begin
      length_seen_next = '0;
    end else if (byte_position < length_seen) begin
      running_sum_next   = running_sum + c;
      byte_position_next = byte_position + 8'd1;
      case (byte_position) inside
        ahfp_pkg::POS_GROUP_HI: group_accum_next = {hex[3:0], 4'b0000};
        ahfp_pkg::POS_GROUP_LO: group_accum_next = group_accum + hex;
        ahfp_pkg::POS_INDEX_HI: index_accum_next = {hex[3:0], 4'b0000};
        ahfp_pkg::POS_INDEX_LO: index_accum_next = index_accum + hex;
        ahfp_pkg::POS_BATT_FIRST, ahfp_pkg::POS_BATT_LAST: begin
          if (!decimal_stopped[0]) begin
            if (dig_ok) begin
              battery_accum_next = 7'(battery_accum * 7'd10) + 7'(digit);
            end else begin
              decimal_stopped_next[0] = 1'b1;
            end
          end
        end
        [ahfp_pkg::POS_TMO_FIRST:ahfp_pkg::POS_TMO_LAST]: begin
          if (!decimal_stopped[1]) begin
            if (dig_ok) begin
              timeout_accum_next = 14'(timeout_accum * 14'd10) + 14'(digit);
            end else begin
              decimal_stopped_next[1] = 1'b1;
            end
          end
        end
        ahfp_pkg::POS_ENTRY_0: entry_accum_next[31:24] = entry_accum[31:24] | c;
        ahfp_pkg::POS_ENTRY_1: entry_accum_next[23:16] = entry_accum[23:16] | c;
        ahfp_pkg::POS_ENTRY_2: entry_accum_next[15:8]  = entry_accum[15:8] | c;
        ahfp_pkg::POS_ENTRY_3: entry_accum_next[7:0]   = entry_accum[7:0] | c;
        default: ;
      endcase
    end else begin
      checksum_high_nibble_next = hex[3:0];
      byte_position_next        = ahfp_pkg::POS_AWAIT_START;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= ahfp_pkg::POS_AWAIT_START;
      length_seen   <= '0;
    end else if (go) begin
      byte_position <= byte_position_next;
      length_seen   <= length_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      running_sum          <= running_sum_next;
      checksum_high_nibble <= checksum_high_nibble_next;
      group_accum          <= group_accum_next;
      index_accum          <= index_accum_next;
      battery_accum        <= battery_accum_next;
      timeout_accum        <= timeout_accum_next;
      entry_accum          <= entry_accum_next;
      decimal_stopped      <= decimal_stopped_next;
    end
  end

`ifndef SYNTHESIS
  a_len_legal: assert property (@(posedge clk) disable iff (rst)
    length_seen != '0 |-> length_seen >= ahfp_pkg::MIN_LENGTH)
    else $error("frame length below minimum held");

  a_pos_in_frame: assert property (@(posedge clk) disable iff (rst)
    length_seen != '0 |-> byte_position <= length_seen)
    else $error("byte position past frame length");

  a_pos_no_frame: assert property (@(posedge clk) disable iff (rst)
    length_seen == '0 |-> byte_position <= ahfp_pkg::POS_LENGTH)
    else $error("byte position advanced without a length");

  a_frame_closes: assert property (@(posedge clk) disable iff (rst)
    go && full |=> length_seen == '0 && byte_position == ahfp_pkg::POS_AWAIT_START)
    else $error("parser did not return to start after a record");
`endif

endmodule

/* src/ahfp_out_reg.sv */
// result register: holds one record until the receiver takes it
`timescale 1ns / 1ps

module ahfp_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  ahfp_pkg::record_t rec_in,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              room,
  output ahfp_pkg::record_t rec_out
);

  assign room = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rec_out <= rec_in;
    end
  end

endmodule

/* src/ascii_hex_frame_parser.sv */
// top level of the ascii hex frame parser
`timescale 1ns / 1ps
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+----------------------------------------
//  in       | to block  | in_valid / in_stall  | rx_byte
//  out      | from block| out_valid / out_stall| status, group_number, device_index,
//           |           |                      | battery_level, timeout_value,
//           |           |                      | entry_chars, frame_length
//
//  one byte per cycle sustained unless a record waits on a full result register; a request
//  is parsed straight out of the input register, and its record shows in the result
//  register in the cycle after it is parsed
//  rst is synchronous, active high; it puts the parser back to awaiting a start byte
//  a byte that makes no record moves on even while the result register is stalled
//  a byte that makes a record waits in the input register until the result register
//  frees up, and in_stall holds the next request off while it waits

module ascii_hex_frame_parser (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [7:0]  group_number,
  output logic [7:0]  device_index,
  output logic [6:0]  battery_level,
  output logic [13:0] timeout_value,
  output logic [31:0] entry_chars,
  output logic [7:0]  frame_length
);

  logic              held_valid;   // input register holds a request
  logic [7:0]        held_byte;
  logic              take;         // parser consumes the held byte this cycle
  logic              emits;        // held byte closes or drops a frame
  logic              room;         // result register can load this cycle
  ahfp_pkg::record_t rec_new;
  ahfp_pkg::record_t rec_out;

  // a byte is taken unless it makes a record and the result register is full
  assign take = held_valid && (!emits || room);

  ahfp_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .take       (take),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  // frame state machine and field accumulators
  ahfp_core u_core (
    .clk   (clk),
    .rst   (rst),
    .go    (take),
    .c     (held_byte),
    .emits (emits),
    .rec   (rec_new)
  );

  ahfp_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (take && emits),
    .rec_in    (rec_new),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .room      (room),
    .rec_out   (rec_out)
  );

  // fan the record out to the payload ports
  assign status        = rec_out.status;
  assign group_number  = rec_out.group_number;
  assign device_index  = rec_out.device_index;
  assign battery_level = rec_out.battery_level;
  assign timeout_value = rec_out.timeout_value;
  assign entry_chars   = rec_out.entry_chars;
  assign frame_length  = rec_out.frame_length;

endmodule

/* verif/tb_ascii_hex_frame_parser.sv */
// testbench for the ascii hex frame parser: framed byte stream in, checked records out
`timescale 1ns / 1ps

module tb_ascii_hex_frame_parser;

  // the long receiver hold plus the longest sender gap stays far below this
  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_CYCLES = 10;
  localparam int RANDOM_BYTES = 500;

  // tracks the parser byte by byte and keeps the records it must produce, oldest first
  class frame_scoreboard;
    ahfp_pkg::record_t expected_q[$];
    int          mismatches = 0;
    int          requests_taken = 0;
    // parser image
    int unsigned frame_pos = 0;
    int unsigned frame_len = 0;
    logic [7:0]  sum_acc = '0;
    logic [3:0]  sum_hi = '0;
    logic [7:0]  group_acc = '0;
    logic [7:0]  index_acc = '0;
    logic [6:0]  batt_acc = '0;
    logic [13:0] tmo_acc = '0;
    logic [31:0] entry_acc = '0;
    logic [1:0]  dec_frozen = '0;

    function void clear_fields();
      sum_acc    = '0;
      sum_hi     = '0;
      group_acc  = '0;
      index_acc  = '0;
      batt_acc   = '0;
      tmo_acc    = '0;
      entry_acc  = '0;
      dec_frozen = '0;
    endfunction

    function bit is_dec(logic [7:0] c);
      return c >= ahfp_pkg::CHAR_ZERO && c <= ahfp_pkg::CHAR_NINE;
    endfunction

    // digits and upper case a-f decode as usual, everything else counts from 'a'
    function logic [7:0] char_value(logic [7:0] c);
      logic [7:0] base;
      logic [7:0] offset;
      base = ahfp_pkg::CHAR_LOWER_A;
      offset = 8'd10;
      if (is_dec(c)) begin
        base = ahfp_pkg::CHAR_ZERO;
        offset = 8'd0;
      end else if (c >= ahfp_pkg::CHAR_UPPER_A && c <= ahfp_pkg::CHAR_UPPER_F) begin
        base = ahfp_pkg::CHAR_UPPER_A;
      end
      return c - base + offset;
    endfunction

    function void push_record(ahfp_pkg::status_t st, logic [7:0] flen, bit full);
      ahfp_pkg::record_t r;
      r = '0;
      r.status = st;
      r.frame_length = flen;
      if (full) begin
        r.group_number  = group_acc;
        r.device_index  = index_acc;
        r.battery_level = batt_acc;
        r.timeout_value = tmo_acc;
        r.entry_chars   = entry_acc;
      end
      expected_q.push_back(r);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_request(logic [7:0] c);
      logic [7:0]         v;
      ahfp_pkg::status_t  st;
      v = char_value(c);
      requests_taken++;
      if (frame_len == 0) begin
        if (frame_pos == 0) begin
          if (c == ahfp_pkg::START_BYTE) begin
            clear_fields();
            frame_pos = 1;
          end else begin
            push_record(ahfp_pkg::STATUS_DROPPED, 8'd0, 1'b0);
          end
        end else if (c < ahfp_pkg::MIN_LENGTH) begin
          frame_pos = 0;
          clear_fields();
          push_record(ahfp_pkg::STATUS_DROPPED, c, 1'b0);
        end else begin
          frame_len = c;
          sum_acc = c;
          frame_pos = 2;
        end
      end else if (frame_pos == 0) begin
        // second checksum character closes the frame
        if (8'({sum_hi, 4'h0} + v) == sum_acc) begin
          st = ahfp_pkg::STATUS_GOOD;
        end else begin
          st = ahfp_pkg::STATUS_BAD_SUM;
        end
        push_record(st, frame_len[7:0], 1'b1);
        frame_len = 0;
      end else if (frame_pos < frame_len) begin
        sum_acc = sum_acc + c;
        if (frame_pos == ahfp_pkg::POS_GROUP_HI) begin
          group_acc = {v[3:0], 4'h0};
        end else if (frame_pos == ahfp_pkg::POS_GROUP_LO) begin
          group_acc = group_acc + v;
        end else if (frame_pos == ahfp_pkg::POS_INDEX_HI) begin
          index_acc = {v[3:0], 4'h0};
        end else if (frame_pos == ahfp_pkg::POS_INDEX_LO) begin
          index_acc = index_acc + v;
        end else if (frame_pos == ahfp_pkg::POS_BATT_FIRST ||
                     frame_pos == ahfp_pkg::POS_BATT_LAST) begin
          if (!dec_frozen[0]) begin
            if (is_dec(c)) batt_acc = 7'(batt_acc * 10 + (c - ahfp_pkg::CHAR_ZERO));
            else dec_frozen[0] = 1'b1;
          end
        end else if (frame_pos >= ahfp_pkg::POS_TMO_FIRST &&
                     frame_pos <= ahfp_pkg::POS_TMO_LAST) begin
          if (!dec_frozen[1]) begin
            if (is_dec(c)) tmo_acc = 14'(tmo_acc * 10 + (c - ahfp_pkg::CHAR_ZERO));
            else dec_frozen[1] = 1'b1;
          end
        end else if (frame_pos >= ahfp_pkg::POS_ENTRY_0 &&
                     frame_pos <= ahfp_pkg::POS_ENTRY_3) begin
          entry_acc = entry_acc | (32'(c) << (8 * (ahfp_pkg::POS_ENTRY_3 - frame_pos)));
        end
        frame_pos++;
      end else begin
        // first checksum character
        sum_hi = v[3:0];
        frame_pos = 0;
      end
    endfunction

    task report(string msg);
      $display("mismatch after %0d requests: %s", requests_taken, msg);
      mismatches++;
    endtask

    task check_record(ahfp_pkg::record_t got);
      ahfp_pkg::record_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("record %h with nothing pending", got));
        return;
      end
      want = expected_q.pop_front();
      if (got.status != want.status)
        report($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.group_number != want.group_number)
        report($sformatf("group_number %h, expected %h", got.group_number, want.group_number));
      if (got.device_index != want.device_index)
        report($sformatf("device_index %h, expected %h", got.device_index, want.device_index));
      if (got.battery_level != want.battery_level)
        report($sformatf("battery_level %0d, expected %0d",
                         got.battery_level, want.battery_level));
      if (got.timeout_value != want.timeout_value)
        report($sformatf("timeout_value %0d, expected %0d",
                         got.timeout_value, want.timeout_value));
      if (got.entry_chars != want.entry_chars)
        report($sformatf("entry_chars %h, expected %h", got.entry_chars, want.entry_chars));
      if (got.frame_length != want.frame_length)
        report($sformatf("frame_length %0d, expected %0d", got.frame_length, want.frame_length));
    endtask
  endclass

  // every input known from time zero
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [7:0]  group_number;
  logic [7:0]  device_index;
  logic [6:0]  battery_level;
  logic [13:0] timeout_value;
  logic [31:0] entry_chars;
  logic [7:0]  frame_length;

  frame_scoreboard sb = new();

  int unsigned bytes_sent = 0;
  int unsigned burst_left = 0;
  int unsigned quiet_cycles = 0;
  bit          long_hold_done = 1'b0;

  ascii_hex_frame_parser dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .group_number  (group_number),
    .device_index  (device_index),
    .battery_level (battery_level),
    .timeout_value (timeout_value),
    .entry_chars   (entry_chars),
    .frame_length  (frame_length)
  );

  always #10 clk = ~clk;

  // sample both channels at the rising edge; a quiet stretch that never ends is a hang
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_request(rx_byte);
      if (out_valid && !out_stall) begin
        sb.check_record(ahfp_pkg::record_t'({status, group_number, device_index,
                                             battery_level, timeout_value, entry_chars,
                                             frame_length}));
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // one request; the sender runs in bursts, some long with no gap at all
  task automatic push_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 12);
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // digits for 0-9, upper or lower case letters for 10-15
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return ahfp_pkg::CHAR_ZERO + v;
    if ($urandom_range(0, 1) == 0) return ahfp_pkg::CHAR_UPPER_A + v - 8'd10;
    return ahfp_pkg::CHAR_LOWER_A + v - 8'd10;
  endfunction

  // mostly legal characters for each field, with the odd stray byte to break them
  function automatic logic [7:0] payload_char(input int unsigned p);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (p >= ahfp_pkg::POS_GROUP_HI && p <= ahfp_pkg::POS_INDEX_LO && r < 85)
      return hex_char(4'($urandom));
    if (p >= ahfp_pkg::POS_BATT_FIRST && p <= ahfp_pkg::POS_TMO_LAST && r < 80)
      return ahfp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
    return 8'($urandom);
  endfunction

  // start byte, length and, for a legal length, payload and two checksum characters,
  // cut short after cut bytes; spoil shifts the checksum so the frame must be flagged
  task automatic send_frame(input logic [7:0] flen, input logic [7:0] body[$],
                            input bit spoil, input int unsigned cut);
    logic [7:0] frame_q[$];
    logic [7:0] sum;
    sum = flen;
    frame_q.push_back(ahfp_pkg::START_BYTE);
    frame_q.push_back(flen);
    if (flen >= ahfp_pkg::MIN_LENGTH) begin
      foreach (body[i]) begin
        frame_q.push_back(body[i]);
        sum = sum + body[i];
      end
      if (spoil) sum = sum + 8'($urandom_range(1, 255));
      frame_q.push_back(hex_char(sum[7:4]));
      frame_q.push_back(hex_char(sum[3:0]));
      // now and then a random byte in place of the first checksum character
      if (!spoil && $urandom_range(0, 19) == 0) frame_q[frame_q.size() - 2] = 8'($urandom);
    end
    for (int i = 0; i < frame_q.size() && i < cut; i++) push_byte(frame_q[i]);
  endtask

  // receiver: stretches of steady, light, heavy or alternating stall, and once a long
  // hold-off while the sender keeps offering, so that the block backs up into in_stall
  initial begin
    int unsigned mode;
    int unsigned span;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!long_hold_done && sb.requests_taken >= 200) begin
        long_hold_done = 1'b1;
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(20, 80);
        repeat (span) begin
          @(negedge clk);
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= ~out_stall;
          endcase
        end
      end
    end
  end

  initial begin
    logic [7:0]   body[$];
    logic [127:0] full_text;
    logic [7:0]   flen;
    int unsigned  k;
    int unsigned  cut;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: stray byte while hunting for a start
    push_byte(8'hFF);
    // length one is below the minimum
    body = {};
    send_frame(8'd1, body, 1'b0, 2);
    // shortest legal frame, no payload at all
    send_frame(ahfp_pkg::MIN_LENGTH, body, 1'b0, 4);
    // every field present: lower case hex digit, battery frozen by a non-digit,
    // largest timeout, entry bytes at the extremes
    full_text = {"Fe09-7x9999#", 8'hFF, 8'h00, 8'h80, 8'h7F};
    for (int i = 0; i < 16; i++) body.push_back(full_text[8 * (15 - i) +: 8]);
    send_frame(8'd18, body, 1'b0, 20);

    // random: mostly frames with random content, short payloads common, a few very long;
    // the rest stray bytes, bad lengths and frames cut off part way
    while (bytes_sent < RANDOM_BYTES) begin
      k = $urandom_range(0, 99);
      if (k < 12) begin
        repeat ($urandom_range(1, 3)) push_byte(8'($urandom));
      end else if (k < 17) begin
        push_byte(ahfp_pkg::START_BYTE);
        push_byte(8'($urandom_range(0, 1)));
      end else begin
        k = $urandom_range(0, 99);
        if (k < 3) flen = 8'($urandom_range(128, 255));
        else if (k < 30) flen = 8'($urandom_range(2, 8));
        else flen = 8'($urandom_range(9, 24));
        body = {};
        for (int p = ahfp_pkg::POS_PAYLOAD; p < flen; p++) body.push_back(payload_char(p));
        cut = ($urandom_range(0, 99) < 8) ? $urandom_range(2, flen + 1) : flen + 2;
        send_frame(flen, body, $urandom_range(0, 99) < 20, cut);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    // let any stray record show up before the verdict
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
